@@ rtl/yq2rgba_pkg.sv @@
// Package with request/result types, format codes and ROM helpers for the quad converter.
`default_nettype none

package yq2rgba_pkg;

  // Output pixel formats held in the format register.
  typedef enum logic [1:0] {
    FMT_XRGB  = 2'd0,
    FMT_RGB   = 2'd1,
    FMT_RGBA  = 2'd2,
    FMT_UNSUP = 2'd3
  } pixel_format_t;

  // Pixel positions inside the quad, in raster order.
  localparam logic [1:0] SLOT_TOP_LEFT     = 2'd0;
  localparam logic [1:0] SLOT_TOP_RIGHT    = 2'd1;
  localparam logic [1:0] SLOT_BOTTOM_LEFT  = 2'd2;
  localparam logic [1:0] SLOT_BOTTOM_RIGHT = 2'd3;

  // Coefficients in thousandths and sample offsets.
  localparam int COEF_Y        = 1164;
  localparam int COEF_RV       = 1596;
  localparam int COEF_GU       = 391;
  localparam int COEF_GV       = 813;
  localparam int COEF_BU       = 2018;
  localparam int LUMA_OFFSET   = 16;
  localparam int CHROMA_OFFSET = 128;
  localparam logic [7:0] MAX_COMPONENT = 8'd255;

  // One request: a luma quad, its chroma pair and the alpha-plane quad.
  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic [7:0] alpha_luma_top_left;
    logic [7:0] alpha_luma_top_right;
    logic [7:0] alpha_luma_bottom_left;
    logic [7:0] alpha_luma_bottom_right;
    logic [7:0] alpha_chroma_v;
  } quad_in_t;

  // One result pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] pixel_slot;
    logic       last;
    logic       format_error;
  } pixel_out_t;

  // Control tag that travels with each pixel through the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] slot;
    logic       last;
    logic       err;
    logic       alpha_on;
  } pix_tag_t;

  // Samples of one pixel as they enter the pipeline.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] alpha_luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic [7:0] alpha_chroma_v;
  } pix_samples_t;

  // ROM entry: trunc((coef * 2^frac + 500) * t / 1000), evaluated at elaboration.
  function automatic longint rom_entry(input longint coef_milli, input longint t,
                                       input int frac);
    longint scaled;
    scaled = coef_milli * (longint'(1) << frac) + 64'sd500;
    return (scaled * t) / 1000;
  endfunction

endpackage

`default_nettype wire

@@ rtl/yq2rgba_pixel_pipe.sv @@
// Three-stage pixel datapath: ROM lookup, component sums, shift and clamp.
`default_nettype none

module yq2rgba_pixel_pipe #(
  parameter int FRACTION_BITS = 13
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire yq2rgba_pkg::pix_tag_t     pix_tag,
  input  wire yq2rgba_pkg::pix_samples_t pix_smp,
  output logic                           out_valid,
  output yq2rgba_pkg::pixel_out_t        out_data
);
  import yq2rgba_pkg::*;

  // Entry magnitude stays below 2.02 * 2^F * 240 < 2^(F+9).
  localparam int RW = FRACTION_BITS + 10;
  localparam int SW = RW + 2;

  // Constant lookup tables built at elaboration.
  logic signed [RW-1:0] y_tab  [256];
  logic signed [RW-1:0] rv_tab [256];
  logic signed [RW-1:0] gu_tab [256];
  logic signed [RW-1:0] gv_tab [256];
  logic signed [RW-1:0] bu_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_rom
    assign y_tab[i]  = RW'(rom_entry(COEF_Y,  longint'(i - LUMA_OFFSET),   FRACTION_BITS));
    assign rv_tab[i] = RW'(rom_entry(COEF_RV, longint'(i - CHROMA_OFFSET), FRACTION_BITS));
    assign gu_tab[i] = RW'(rom_entry(COEF_GU, longint'(i - CHROMA_OFFSET), FRACTION_BITS));
    assign gv_tab[i] = RW'(rom_entry(COEF_GV, longint'(i - CHROMA_OFFSET), FRACTION_BITS));
    assign bu_tab[i] = RW'(rom_entry(COEF_BU, longint'(i - CHROMA_OFFSET), FRACTION_BITS));
  end

  // Floor shift by the fraction width, then clamp to 0..255.
  function automatic logic [7:0] scale_clamp(input logic signed [SW-1:0] sum);
    logic signed [SW-1:0] q;
    q = sum >>> FRACTION_BITS;
    if (q[SW-1]) begin
      return 8'd0;
    end else if (|q[SW-2:8]) begin
      return MAX_COMPONENT;
    end else begin
      return q[7:0];
    end
  endfunction

  // Stage 1: table lookups.
  pix_tag_t             s1_tag_r;
  logic signed [RW-1:0] s1_y_r, s1_ay_r, s1_rv_r, s1_gu_r, s1_gv_r, s1_bu_r, s1_arv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.valid <= 1'b0;
    end else begin
      s1_tag_r.valid <= pix_tag.valid;
    end
    s1_tag_r.slot     <= pix_tag.slot;
    s1_tag_r.last     <= pix_tag.last;
    s1_tag_r.err      <= pix_tag.err;
    s1_tag_r.alpha_on <= pix_tag.alpha_on;
    s1_y_r   <= y_tab[pix_smp.luma];
    s1_ay_r  <= y_tab[pix_smp.alpha_luma];
    s1_rv_r  <= rv_tab[pix_smp.chroma_v];
    s1_gu_r  <= gu_tab[pix_smp.chroma_u];
    s1_gv_r  <= gv_tab[pix_smp.chroma_v];
    s1_bu_r  <= bu_tab[pix_smp.chroma_u];
    s1_arv_r <= rv_tab[pix_smp.alpha_chroma_v];
  end

  // Stage 2: component sums.
  pix_tag_t             s2_tag_r;
  logic signed [SW-1:0] s2_r_r, s2_g_r, s2_b_r, s2_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r.valid <= 1'b0;
    end else begin
      s2_tag_r.valid <= s1_tag_r.valid;
    end
    s2_tag_r.slot     <= s1_tag_r.slot;
    s2_tag_r.last     <= s1_tag_r.last;
    s2_tag_r.err      <= s1_tag_r.err;
    s2_tag_r.alpha_on <= s1_tag_r.alpha_on;
    s2_r_r <= SW'(s1_y_r) + SW'(s1_rv_r);
    s2_g_r <= SW'(s1_y_r) - (SW'(s1_gu_r) + SW'(s1_gv_r));
    s2_b_r <= SW'(s1_y_r) + SW'(s1_bu_r);
    s2_a_r <= SW'(s1_ay_r) + SW'(s1_arv_r);
  end

  // Stage 3: shift, clamp and format the result pixel.
  logic       out_valid_r;
  pixel_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_tag_r.valid;
    end
    out_data_r.last         <= s2_tag_r.last;
    out_data_r.format_error <= s2_tag_r.err;
    if (s2_tag_r.err) begin
      out_data_r.red        <= 8'd0;
      out_data_r.green      <= 8'd0;
      out_data_r.blue       <= 8'd0;
      out_data_r.alpha      <= 8'd0;
      out_data_r.pixel_slot <= SLOT_TOP_LEFT;
    end else begin
      out_data_r.red        <= scale_clamp(s2_r_r);
      out_data_r.green      <= scale_clamp(s2_g_r);
      out_data_r.blue       <= scale_clamp(s2_b_r);
      out_data_r.alpha      <= s2_tag_r.alpha_on ? scale_clamp(s2_a_r) : MAX_COMPONENT;
      out_data_r.pixel_slot <= s2_tag_r.slot;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/yuv420_quad_to_rgba.sv @@
// Top level: format register, quad holding register with pixel sequencer, pixel pipeline.
// Each pixel passes the holding register and the three datapath stages before it strobes.
// Throughput: one pixel per cycle on the result port while a request issues; a new quad is
// accepted as its last pixel issues, and an unsupported-format request gives one result.
// The pixel sequencer in front of the three-stage datapath sets this rate.
// Reset (synchronous, active low) sets the format to xrgb and empties the pipeline;
// results cannot be stalled by the receiver.
`default_nettype none

module yuv420_quad_to_rgba #(
  parameter int FRACTION_BITS = 13
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire yq2rgba_pkg::quad_in_t   in_quad,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_wdata,
  output logic                         out_valid,
  output yq2rgba_pkg::pixel_out_t      out_data
);
  import yq2rgba_pkg::*;

  // Format register.
  pixel_format_t fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_XRGB;
    end else if (cfg_we) begin
      fmt_r <= pixel_format_t'(cfg_wdata);
    end
  end

  // Holding register for the current request and the slot sequencer.
  logic          buf_valid_r, buf_valid_nxt;
  quad_in_t      buf_r;
  pixel_format_t buf_fmt_r;
  logic [1:0]    slot_r, slot_nxt;
  logic          issue_last;
  logic          accept;

  assign issue_last = (buf_fmt_r == FMT_UNSUP) || (slot_r == SLOT_BOTTOM_RIGHT);
  assign busy       = buf_valid_r && !issue_last;
  assign accept     = start && !busy;

  always_comb begin
    buf_valid_nxt = buf_valid_r;
    slot_nxt      = slot_r;
    if (accept) begin
      buf_valid_nxt = 1'b1;
      slot_nxt      = SLOT_TOP_LEFT;
    end else if (buf_valid_r && issue_last) begin
      buf_valid_nxt = 1'b0;
    end else if (buf_valid_r) begin
      slot_nxt = slot_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      slot_r      <= SLOT_TOP_LEFT;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      slot_r      <= slot_nxt;
    end
    if (accept) begin
      buf_r     <= in_quad;
      buf_fmt_r <= fmt_r;
    end
  end

  // Pick the samples of the pixel issued this cycle.
  pix_tag_t     pix_tag;
  pix_samples_t pix_smp;

  always_comb begin
    pix_tag.valid    = buf_valid_r;
    pix_tag.slot     = slot_r;
    pix_tag.last     = issue_last;
    pix_tag.err      = (buf_fmt_r == FMT_UNSUP);
    pix_tag.alpha_on = (buf_fmt_r == FMT_RGBA);
    pix_smp.chroma_u       = buf_r.chroma_u;
    pix_smp.chroma_v       = buf_r.chroma_v;
    pix_smp.alpha_chroma_v = buf_r.alpha_chroma_v;
    case (slot_r)
      SLOT_TOP_LEFT: begin
        pix_smp.luma       = buf_r.luma_top_left;
        pix_smp.alpha_luma = buf_r.alpha_luma_top_left;
      end
      SLOT_TOP_RIGHT: begin
        pix_smp.luma       = buf_r.luma_top_right;
        pix_smp.alpha_luma = buf_r.alpha_luma_top_right;
      end
      SLOT_BOTTOM_LEFT: begin
        pix_smp.luma       = buf_r.luma_bottom_left;
        pix_smp.alpha_luma = buf_r.alpha_luma_bottom_left;
      end
      default: begin
        pix_smp.luma       = buf_r.luma_bottom_right;
        pix_smp.alpha_luma = buf_r.alpha_luma_bottom_right;
      end
    endcase
  end

  // Datapath.
  yq2rgba_pixel_pipe #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix_tag  (pix_tag),
    .pix_smp  (pix_smp),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Pixels of one request leave on consecutive cycles.
  a_quad_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("pixel stream of a request was interrupted");

  // A color result closes its request only on the bottom right pixel.
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last && !out_data.format_error |->
      out_data.pixel_slot == SLOT_BOTTOM_RIGHT)
    else $error("last flag on wrong pixel slot");

  // The error result is a single zero pixel.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.format_error |->
      out_data.last && out_data.red == 8'd0 && out_data.green == 8'd0 &&
      out_data.blue == 8'd0 && out_data.alpha == 8'd0 &&
      out_data.pixel_slot == SLOT_TOP_LEFT)
    else $error("format error result not cleared");

  // An accepted request shows up on the result port after the holding register and the lookup, sum and clamp stages.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted request produced no result in time");

endmodule

`default_nettype wire
